>>> src/ssu_pkg.sv
// ----------------------------------------------------------------------------
// ssu_pkg
// shared types and constants of the stride scheduler unit
// ----------------------------------------------------------------------------
package ssu_pkg;

    localparam int PASS_W   = 63;
    localparam int TK_W     = 16;
    localparam int PID_W    = 16;
    localparam int TICKS_W  = 32;
    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 4;
    localparam int QUANT_W  = 32;

    localparam logic [CMD_W-1:0] CMD_ARRIVE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_IO_READY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PREEMPT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BLOCK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd4;

    localparam logic [PASS_W-1:0] PASS_MAX = {PASS_W{1'b1}};

    typedef struct packed {
        logic [PASS_W-1:0] pass;
        logic [TK_W-1:0]   tickets;
        logic [PID_W-1:0]  pid;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{pass: '0, tickets: 16'd1, pid: '0};

endpackage

>>> src/ssu_div.sv
// ----------------------------------------------------------------------------
// ssu_div
// restoring divider, one quotient bit per cycle, of 2^(Q_W-1) by tickets
// ----------------------------------------------------------------------------
module ssu_div
    import ssu_pkg::*;
#(
    parameter int Q_W = 21
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [TK_W-1:0]     divisor,
    output logic                done,
    output logic [Q_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TK_W-1:0]   rem_reg, rem_next;
    logic [TK_W-1:0]   dvs_reg, dvs_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [TK_W:0]     trial;
    logic              num_bit;

    assign num_bit = (cnt_reg == CNT_W'(Q_W));
    assign trial   = {rem_reg, num_bit};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(Q_W);
            rem_next  = '0;
            dvs_next  = divisor;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = TK_W'(trial - {1'b0, dvs_reg});
                q_next   = {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[TK_W-1:0];
                q_next   = {q_reg[Q_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> src/stride_scheduler_unit.sv
// ----------------------------------------------------------------------------
// stride_scheduler_unit
// proportional-share stride scheduler over a table of process slots
// ----------------------------------------------------------------------------
// arrival and io ready pass the wait, read and output states to the result word
// preempt and block go on to the bit-serial divider, multiply and add states
// dispatch scans the table, one table read per slot
// one word at a time; the next word is taken once the result is registered
// reset clears ready marks, virtual time and per-slot valid bits at once
module stride_scheduler_unit
    import ssu_pkg::*;
#(
    parameter int NUM_SLOTS    = 16,
    parameter int STRIDE_SHIFT = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // slot, tickets, proc_id, ticks_run, zero pad
    input  logic [2:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // granted_slot, slice_length, zero pad
    output logic        m_tuser,   // granted
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int SCN_W  = $clog2(NUM_SLOTS + 1);
    localparam int Q_W    = STRIDE_SHIFT + 1;
    localparam int PROD_W = Q_W + TICKS_W;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b00000001,
        ST_RD   = 8'b00000010,
        ST_DIV  = 8'b00000100,
        ST_MUL  = 8'b00001000,
        ST_ADD  = 8'b00010000,
        ST_SCAN = 8'b00100000,
        ST_OUT  = 8'b01000000,
        ST_WAIT = 8'b10000000
    } state_t;

    state_t                state_reg, state_next;
    logic [QUANT_W-1:0]    quant_reg, quant_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [TK_W-1:0]       tk_reg, tk_next;
    logic [PID_W-1:0]      pid_reg, pid_next;
    logic [TICKS_W-1:0]    ticks_reg, ticks_next;
    logic [NUM_SLOTS-1:0]  ready_reg, ready_next;
    logic [NUM_SLOTS-1:0]  vld_reg, vld_next;
    logic [PASS_W-1:0]     vt_reg, vt_next;
    entry_t                ent_reg, ent_next;
    logic [Q_W-1:0]        stride_reg, stride_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [SCN_W-1:0]      issue_reg, issue_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    entry_t                best_reg, best_next;
    logic                  res_grant_reg, res_grant_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;
    logic [QUANT_W-1:0]    res_len_reg, res_len_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  m_tuser_reg, m_tuser_next;
    logic [39:0]           m_tdata_reg, m_tdata_next;

    entry_t                mem [NUM_SLOTS];
    entry_t                rd_data_reg;
    logic                  rd_vld_reg;
    entry_t                rd_word;
    logic [IDX_W-1:0]      mem_raddr;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    entry_t                mem_wdata;

    logic                  div_go_reg;
    logic                  div_done;
    logic [Q_W-1:0]        div_q;
    logic [IDX_W-1:0]      slot_idx;
    logic                  s_fire;
    logic                  cfg_we;
    logic [PASS_W:0]       sum;

    ssu_div #(.Q_W(Q_W)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .divisor  (ent_reg.tickets),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign slot_idx = IDX_W'(slot_reg);
    assign rd_word  = rd_vld_reg ? rd_data_reg : ENTRY_RESET;
    assign cfg_we   = psel && penable && pwrite && (paddr == 3'd0);
    assign sum      = {1'b0, ent_reg.pass} + (PASS_W + 1)'(prod_reg);

    assign pready   = 1'b1;
    assign prdata   = (paddr == 3'd0) ? quant_reg : 32'd0;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next     = state_reg;
        quant_next     = cfg_we ? pwdata : quant_reg;
        cmd_next       = cmd_reg;
        slot_next      = slot_reg;
        tk_next        = tk_reg;
        pid_next       = pid_reg;
        ticks_next     = ticks_reg;
        ready_next     = ready_reg;
        vld_next       = vld_reg;
        vt_next        = vt_reg;
        ent_next       = ent_reg;
        stride_next    = stride_reg;
        prod_next      = prod_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        res_grant_next = res_grant_reg;
        res_slot_next  = res_slot_reg;
        res_len_next   = res_len_reg;
        m_tvalid_next  = (m_tvalid_reg && m_tready) ? 1'b0 : m_tvalid_reg;
        m_tuser_next   = m_tuser_reg;
        m_tdata_next   = m_tdata_reg;
        mem_raddr      = slot_idx;
        mem_we         = 1'b0;
        mem_waddr      = slot_idx;
        mem_wdata      = ent_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    cmd_next       = s_tuser;
                    slot_next      = s_tdata[3:0];
                    tk_next        = s_tdata[19:4];
                    pid_next       = s_tdata[35:20];
                    ticks_next     = s_tdata[67:36];
                    res_grant_next = 1'b0;
                    res_slot_next  = '0;
                    res_len_next   = '0;
                    if (s_tuser == CMD_DISPATCH)
                    begin
                        issue_next = '0;
                        pend_next  = 1'b0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                    else if ((s_tuser > CMD_DISPATCH) ||
                             (32'(s_tdata[3:0]) >= 32'(NUM_SLOTS)))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT:
            begin
                state_next = ST_RD;
            end
            ST_RD:
            begin
                ent_next = rd_word;
                unique case (cmd_reg)
                    CMD_ARRIVE:
                    begin
                        mem_we              = 1'b1;
                        mem_wdata.pass      = vt_reg;
                        mem_wdata.tickets   = (tk_reg == '0) ? TK_W'(1) : tk_reg;
                        mem_wdata.pid       = pid_reg;
                        vld_next[slot_idx]  = 1'b1;
                        ready_next[slot_idx] = 1'b1;
                        state_next          = ST_OUT;
                    end
                    CMD_IO_READY:
                    begin
                        mem_we              = 1'b1;
                        mem_wdata           = rd_word;
                        if (rd_word.pass < vt_reg)
                        begin
                            mem_wdata.pass = vt_reg;
                        end
                        vld_next[slot_idx]  = 1'b1;
                        ready_next[slot_idx] = 1'b1;
                        state_next          = ST_OUT;
                    end
                    default:
                    begin
                        state_next = ST_DIV;
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    stride_next = div_q;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(stride_reg) * PROD_W'(ticks_reg);
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                mem_we             = 1'b1;
                mem_wdata          = ent_reg;
                mem_wdata.pass     = sum[PASS_W] ? PASS_MAX : sum[PASS_W-1:0];
                vld_next[slot_idx] = 1'b1;
                if (cmd_reg == CMD_PREEMPT)
                begin
                    ready_next[slot_idx] = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_SCAN:
            begin
                mem_raddr = IDX_W'(issue_reg);
                if (pend_reg && ready_reg[pend_idx_reg] &&
                    (!found_reg ||
                     ({rd_word.pass, rd_word.pid} < {best_reg.pass, best_reg.pid})))
                begin
                    found_next    = 1'b1;
                    best_idx_next = pend_idx_reg;
                    best_next     = rd_word;
                end
                if (issue_reg < SCN_W'(NUM_SLOTS))
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = IDX_W'(issue_reg);
                    issue_next    = issue_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (found_reg)
                        begin
                            ready_next[best_idx_reg] = 1'b0;
                            vt_next        = best_reg.pass;
                            res_grant_next = 1'b1;
                            res_slot_next  = SLOT_W'(best_idx_reg);
                            res_len_next   = quant_reg;
                        end
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_grant_reg;
                    m_tdata_next  = {4'd0, res_len_reg, res_slot_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_go_reg <= 1'b0;
        end
        else
        begin
            div_go_reg <= (state_reg == ST_RD) &&
                          (cmd_reg == CMD_PREEMPT || cmd_reg == CMD_BLOCK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            quant_reg    <= 32'd10;
            ready_reg    <= '0;
            vld_reg      <= '0;
            vt_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            quant_reg    <= quant_next;
            ready_reg    <= ready_next;
            vld_reg      <= vld_next;
            vt_reg       <= vt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        slot_reg      <= slot_next;
        tk_reg        <= tk_next;
        pid_reg       <= pid_next;
        ticks_reg     <= ticks_next;
        ent_reg       <= ent_next;
        stride_reg    <= stride_next;
        prod_reg      <= prod_next;
        issue_reg     <= issue_next;
        pend_reg      <= pend_next;
        pend_idx_reg  <= pend_idx_next;
        found_reg     <= found_next;
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        res_grant_reg <= res_grant_next;
        res_slot_reg  <= res_slot_next;
        res_len_reg   <= res_len_next;
        m_tuser_reg   <= m_tuser_next;
        m_tdata_reg   <= m_tdata_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
        rd_vld_reg  <= vld_reg[mem_raddr];
    end

endmodule
